// ===== src/gregdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gregdt_pkg;

    // cycle lengths in days
    localparam logic [17:0] C_CYC400 = 18'd146097;
    localparam logic [15:0] C_CYC100 = 16'd36524;
    localparam logic [10:0] C_CYC4   = 11'd1461;
    localparam logic [8:0]  C_CYC1   = 9'd365;

    // bias so that the biased day count is never negative
    localparam logic [15:0] C_BIAS_CYC = 16'd14700;
    localparam logic [32:0] C_BIAS_M1  = 33'd2147625899;   // 14700 * 146097 - 1

    // reciprocals: floor(2^37 / 146097), ceil(2^26 / 1461), ceil(2^24 / 367)
    localparam logic [19:0] C_K400  = 20'd940737;
    localparam logic [15:0] C_K4    = 16'd45934;
    localparam logic [15:0] C_KMON  = 16'd45715;

    localparam logic [12:0] C_MON_OFS = 13'd373;

    typedef struct packed {
        logic              valid;
        logic signed [15:0] n400;
        logic [17:0]        rem;
    } t_div400;

    // days from 1 january to the first of month m
    function automatic logic [8:0] f_days_before(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        logic [8:0] adj;
        begin
            case (m)
                4'd1:    base = 9'd0;
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd61;
                4'd4:    base = 9'd92;
                4'd5:    base = 9'd122;
                4'd6:    base = 9'd153;
                4'd7:    base = 9'd183;
                4'd8:    base = 9'd214;
                4'd9:    base = 9'd245;
                4'd10:   base = 9'd275;
                4'd11:   base = 9'd306;
                4'd12:   base = 9'd336;
                default: base = 9'd0;
            endcase
            if (m > 4'd2) begin
                adj = leap ? 9'd1 : 9'd2;
            end else begin
                adj = 9'd0;
            end
            f_days_before = base - adj;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/gregdt_div400.sv =====
`timescale 1ns / 1ps
`default_nettype none

// floor division of (day - 1) by the 400-year cycle, four register stages
module gregdt_div400
    import gregdt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_day_number,
    output t_div400                 o_res
);

    logic        r1_valid, r2_valid, r3_valid, r4_valid;
    logic [32:0] r1_u, r2_u, r3_u;
    logic [45:0] r2_p;
    logic [14:0] r3_q;
    logic [32:0] r3_m;
    logic signed [15:0] r4_n400;
    logic [17:0] r4_rem;

    logic [32:0] n_u;
    logic [45:0] n_p;
    logic [14:0] w_qest;
    logic [32:0] n_m;
    logic [32:0] w_diff;
    logic [18:0] w_r;
    logic [15:0] w_q;
    logic [17:0] n_rem;
    logic [15:0] n_n400;

    always_comb begin
        n_u    = {i_day_number[31], i_day_number} + C_BIAS_M1;
        n_p    = {20'd0, r1_u[32:7]} * {26'd0, C_K400};
        w_qest = r2_p[44:30];
        n_m    = {18'd0, w_qest} * {15'd0, C_CYC400};
        // estimate is low by at most one cycle
        w_diff = r3_u - r3_m;
        w_r    = w_diff[18:0];
        if (w_r >= {1'b0, C_CYC400}) begin
            n_rem = 18'(w_r - {1'b0, C_CYC400});
            w_q   = {1'b0, r3_q} + 16'd1;
        end else begin
            n_rem = w_r[17:0];
            w_q   = {1'b0, r3_q};
        end
        n_n400 = w_q - C_BIAS_CYC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u    <= n_u;
        r2_u    <= r1_u;
        r2_p    <= n_p;
        r3_u    <= r2_u;
        r3_q    <= w_qest;
        r3_m    <= n_m;
        r4_n400 <= n_n400;
        r4_rem  <= n_rem;
    end

    assign o_res.valid = r4_valid;
    assign o_res.n400  = r4_n400;
    assign o_res.rem   = r4_rem;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid |-> r4_rem < C_CYC400)
        else $error("remainder not below one 400-year cycle");

    a_est_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> (r3_u - r3_m) < {14'd0, C_CYC400, 1'b0})
        else $error("quotient estimate off by more than one");

    a_n400_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid |-> (r4_n400 >= -16'sd14700) && (r4_n400 <= 16'sd14700))
        else $error("400-year cycle count out of range");

endmodule

`default_nettype wire

// ===== src/gregorian_date_from_day_number.sv =====
`timescale 1ns / 1ps
`default_nettype none

// converts a signed fixed day number (day 1 = 0001-01-01, proleptic gregorian)
// into year, month and day of month. fully pipelined: one day number can be
// started every clock cycle, busy is always low, and each result appears with
// o_done once its start beat has passed through the registered stages. the
// stages hold reciprocal multiplies for the 400-year, 4-year and month divisions;
// only the 400-year division is followed by a correction stage. results cannot be
// held off: sample them in the o_done cycle.
module gregorian_date_from_day_number
    import gregdt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_day_number,
    output logic                    o_done,
    output logic signed [23:0]      o_year,
    output logic [3:0]              o_month,
    output logic [4:0]              o_day_of_month
);

    t_div400 w_div;

    gregdt_div400 u_div400 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_day_number (i_day_number),
        .o_res        (w_div)
    );

    assign busy = 1'b0;

    // stage registers
    logic               r5_valid, r6_valid, r7_valid, r8_valid, r9_valid, r10_valid;
    logic signed [15:0] r5_n400, r6_n400, r7_n400;
    logic [2:0]         r5_n100, r6_n100, r7_n100;
    logic [15:0]        r5_d2, r6_d2, r7_d2;
    logic [31:0]        r6_p4;
    logic [4:0]         r7_n4;
    logic [15:0]        r7_m4;
    logic [23:0]        r8_yb;
    logic [2:0]         r8_n1;
    logic               r8_special, r8_leap;
    logic [8:0]         r8_prior, r9_prior, r10_prior;
    logic [23:0]        r9_year, r10_year;
    logic               r9_leap, r10_leap;
    logic [12:0]        r9_x;
    logic [28:0]        r10_pm;
    logic               r_done;
    logic [23:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;

    // next values
    logic [2:0]  n_n100;
    logic [17:0] w_d2full;
    logic [15:0] n_d2;
    logic [31:0] n_p4;
    logic [4:0]  w_n4;
    logic [15:0] n_m4;
    logic [15:0] w_d3full;
    logic [10:0] w_d3;
    logic [2:0]  n_n1;
    logic        n_special, n_leap;
    logic [8:0]  n_prior;
    logic [23:0] n_yb;
    logic [23:0] w_n400x;
    logic [23:0] n_year;
    logic [8:0]  w_leapthr;
    logic [8:0]  w_corr;
    logic [8:0]  w_pc;
    logic [12:0] n_x;
    logic [28:0] n_pm;
    logic [3:0]  w_month;
    logic [8:0]  w_dayfull;

    always_comb begin
        // 100-year cycles within the 400-year cycle, 0 to 4
        if (w_div.rem >= 18'd146096) begin
            n_n100 = 3'd4;
        end else if (w_div.rem >= 18'd109572) begin
            n_n100 = 3'd3;
        end else if (w_div.rem >= 18'd73048) begin
            n_n100 = 3'd2;
        end else if (w_div.rem >= {2'd0, C_CYC100}) begin
            n_n100 = 3'd1;
        end else begin
            n_n100 = 3'd0;
        end
        w_d2full = w_div.rem - 18'({15'd0, n_n100} * {2'd0, C_CYC100});
        n_d2     = w_d2full[15:0];

        n_p4 = {16'd0, r5_d2} * {16'd0, C_K4};

        w_n4 = r6_p4[30:26];
        n_m4 = 16'({11'd0, w_n4} * {5'd0, C_CYC4});

        w_d3full = r7_d2 - r7_m4;
        w_d3     = w_d3full[10:0];
        if (w_d3 >= 11'd1460) begin
            n_n1 = 3'd4;
        end else if (w_d3 >= 11'd1095) begin
            n_n1 = 3'd3;
        end else if (w_d3 >= 11'd730) begin
            n_n1 = 3'd2;
        end else if (w_d3 >= {2'd0, C_CYC1}) begin
            n_n1 = 3'd1;
        end else begin
            n_n1 = 3'd0;
        end
        // last day of a leap cycle stays in the earlier year
        n_special = (r7_n100 == 3'd4) || (n_n1 == 3'd4);
        if (n_special) begin
            n_prior = C_CYC1;
        end else begin
            n_prior = 9'(w_d3 - 11'({8'd0, n_n1} * {2'd0, C_CYC1}));
        end
        n_leap  = n_special ||
                  ((n_n1 == 3'd3) && ((r7_n4 != 5'd24) || (r7_n100 == 3'd3)));
        w_n400x = {{8{r7_n400[15]}}, r7_n400};
        n_yb    = w_n400x * 24'd400 + {21'd0, r7_n100} * 24'd100 + {17'd0, r7_n4, 2'd0};

        n_year    = r8_yb + {21'd0, r8_n1} + {23'd0, !r8_special};
        w_leapthr = 9'd59 + {8'd0, r8_leap};
        if (r8_prior < w_leapthr) begin
            w_corr = 9'd0;
        end else begin
            w_corr = r8_leap ? 9'd1 : 9'd2;
        end
        w_pc = r8_prior + w_corr;
        n_x  = 13'({4'd0, w_pc} * 13'd12) + C_MON_OFS;

        n_pm = {16'd0, r9_x} * {13'd0, C_KMON};

        w_month   = r10_pm[27:24];
        w_dayfull = r10_prior + 9'd1 - f_days_before(w_month, r10_leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r5_valid  <= w_div.valid;
            r6_valid  <= r5_valid;
            r7_valid  <= r6_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
            r_done    <= r10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_n400    <= w_div.n400;
        r5_n100    <= n_n100;
        r5_d2      <= n_d2;
        r6_n400    <= r5_n400;
        r6_n100    <= r5_n100;
        r6_d2      <= r5_d2;
        r6_p4      <= n_p4;
        r7_n400    <= r6_n400;
        r7_n100    <= r6_n100;
        r7_d2      <= r6_d2;
        r7_n4      <= w_n4;
        r7_m4      <= n_m4;
        r8_yb      <= n_yb;
        r8_n1      <= n_n1;
        r8_special <= n_special;
        r8_leap    <= n_leap;
        r8_prior   <= n_prior;
        r9_year    <= n_year;
        r9_leap    <= r8_leap;
        r9_prior   <= r8_prior;
        r9_x       <= n_x;
        r10_year   <= r9_year;
        r10_leap   <= r9_leap;
        r10_prior  <= r9_prior;
        r10_pm     <= n_pm;
        r_year     <= r10_year;
        r_month    <= w_month;
        r_day      <= w_dayfull[4:0];
    end

    assign o_done         = r_done;
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_day;

    a_prior_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r8_valid |-> r8_prior <= C_CYC1)
        else $error("day of year out of range");

    a_month_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month != 5'd0))
        else $error("month or day of month out of range");

    a_short_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_month == 4'd2) |-> o_day_of_month <= 5'd29)
        else $error("february longer than 29 days");

    a_thirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && ((o_month == 4'd4) || (o_month == 4'd6) || (o_month == 4'd9) ||
                   (o_month == 4'd11)) |-> o_day_of_month <= 5'd30)
        else $error("thirty-day month overflow");

endmodule

`default_nettype wire

// ===== dv/tb_gregorian_date_from_day_number.sv =====
`timescale 1ns / 1ps

module tb_gregorian_date_from_day_number;

    localparam longint DAYS_400Y  = 146097;
    localparam longint DAYS_100Y  = 36524;
    localparam longint DAYS_4Y    = 1461;
    localparam longint DAYS_1Y    = 365;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PHASE_ITEMS = 450;

    typedef struct packed {
        logic signed [23:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
    } cal_date_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_day_number = '0;
    logic               o_done;
    logic signed [23:0] o_year;
    logic [3:0]         o_month;
    logic [4:0]         o_day_of_month;

    logic signed [31:0] day_numbers_pending[$];
    cal_date_t          dates_due[$];
    int                 sender_idle_pct = 0;
    logic               beat_taken = 1'b0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    gregorian_date_from_day_number u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_day_number   (i_day_number),
        .o_done         (o_done),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic bit is_leap_year(input longint y);
        longint r;
        r = y - 400 * floor_div(y, 400);
        return (y - 4 * floor_div(y, 4)) == 0 && r != 100 && r != 200 && r != 300;
    endfunction

    // day number of y-m-d, standard fixed-from-gregorian formula
    function automatic longint day_number_of(input longint y, input longint m, input longint d);
        longint p;
        longint f;
        p = y - 1;
        f = 365 * p + floor_div(p, 4) - floor_div(p, 100) + floor_div(p, 400)
            + floor_div(367 * m - 362, 12) + d;
        if (m > 2) begin
            f = f - (is_leap_year(y) ? 1 : 2);
        end
        return f;
    endfunction

    function automatic cal_date_t date_of_day(input logic signed [31:0] dn);
        longint    dnum;
        longint    d0;
        longint    n400;
        longint    d1;
        longint    n100;
        longint    d2;
        longint    n4;
        longint    d3;
        longint    n1;
        longint    y;
        longint    prior;
        longint    corr;
        longint    m;
        longint    dom;
        cal_date_t res;
        dnum = dn;
        d0   = dnum - 1;
        n400 = floor_div(d0, DAYS_400Y);
        d1   = d0 - DAYS_400Y * n400;
        n100 = d1 / DAYS_100Y;
        d2   = d1 % DAYS_100Y;
        n4   = d2 / DAYS_4Y;
        d3   = d2 % DAYS_4Y;
        n1   = d3 / DAYS_1Y;
        y    = 400 * n400 + 100 * n100 + 4 * n4 + n1;
        // last day of a leap cycle stays in the earlier year
        if (!(n100 == 4 || n1 == 4)) begin
            y = y + 1;
        end
        prior = dnum - day_number_of(y, 1, 1);
        if (dnum < day_number_of(y, 3, 1)) begin
            corr = 0;
        end else begin
            corr = is_leap_year(y) ? 1 : 2;
        end
        m   = floor_div(12 * (prior + corr) + 373, 367);
        dom = dnum - day_number_of(y, m, 1) + 1;
        res.year         = y[23:0];
        res.month        = m[3:0];
        res.day_of_month = dom[4:0];
        return res;
    endfunction

    function automatic logic signed [31:0] random_day_number();
        longint dn;
        case ($urandom_range(3))
            0: dn = longint'($signed($urandom()));
            1: dn = longint'($urandom_range(1600000)) - 800000;
            2: begin
                // land on or next to a cycle boundary
                dn = (longint'($urandom_range(28000)) - 14000) * DAYS_400Y
                     + longint'($urandom_range(4)) * DAYS_100Y
                     + longint'($urandom_range(25)) * DAYS_4Y
                     + longint'($urandom_range(4)) * DAYS_1Y
                     + longint'($urandom_range(4)) - 1;
            end
            default: begin
                if ($urandom_range(1)) begin
                    dn = 64'sd2147483647 - longint'($urandom_range(1000));
                end else begin
                    dn = -64'sd2147483648 + longint'($urandom_range(1000));
                end
            end
        endcase
        return dn[31:0];
    endfunction

    // checked at the rising edge, where start and the pending queue are settled
    task automatic wait_all_dates_out();
        @(posedge i_clk);
        while (day_numbers_pending.size() != 0 || start || dates_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver: a beat stays on the port until it is taken
    always @(negedge i_clk) begin
        if (!start || beat_taken) begin
            if (day_numbers_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                start        <= 1'b1;
                i_day_number <= day_numbers_pending.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // accept beats and check results
    always @(posedge i_clk) begin
        cal_date_t due;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        beat_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            dates_due.push_back(date_of_day(i_day_number));
        end
        if (i_rst_n && o_done) begin
            if (dates_due.size() == 0) begin
                $error("unexpected result: year %0d month %0d day %0d",
                       o_year, o_month, o_day_of_month);
                error_count = error_count + 1;
            end else begin
                due = dates_due.pop_front();
                if (o_year !== due.year) begin
                    $error("year: expected %0d, got %0d", due.year, o_year);
                    error_count = error_count + 1;
                end
                if (o_month !== due.month) begin
                    $error("month: expected %0d, got %0d", due.month, o_month);
                    error_count = error_count + 1;
                end
                if (o_day_of_month !== due.day_of_month) begin
                    $error("day_of_month: expected %0d, got %0d",
                           due.day_of_month, o_day_of_month);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, epoch, cycle ends, leap day, bit patterns
        sender_idle_pct = 0;
        day_numbers_pending.push_back(32'sh8000_0000);
        day_numbers_pending.push_back(32'sh7fff_ffff);
        day_numbers_pending.push_back(32'sh8000_0001);
        day_numbers_pending.push_back(32'sh7fff_fffe);
        day_numbers_pending.push_back(0);
        day_numbers_pending.push_back(1);
        day_numbers_pending.push_back(-1);
        day_numbers_pending.push_back(59);
        day_numbers_pending.push_back(60);
        day_numbers_pending.push_back(365);
        day_numbers_pending.push_back(366);
        day_numbers_pending.push_back(1460);
        day_numbers_pending.push_back(1461);
        day_numbers_pending.push_back(36524);
        day_numbers_pending.push_back(36525);
        day_numbers_pending.push_back(146096);
        day_numbers_pending.push_back(146097);
        day_numbers_pending.push_back(146098);
        day_numbers_pending.push_back(-146097);
        day_numbers_pending.push_back(-146096);
        day_numbers_pending.push_back(730179);
        day_numbers_pending.push_back(730180);
        day_numbers_pending.push_back(730485);
        day_numbers_pending.push_back(32'sh5555_5555);
        day_numbers_pending.push_back(32'shaaaa_aaaa);
        wait_all_dates_out();

        sender_idle_pct = 9;
        repeat (PHASE_ITEMS) day_numbers_pending.push_back(random_day_number());
        wait_all_dates_out();

        sender_idle_pct = 80;
        repeat (PHASE_ITEMS) day_numbers_pending.push_back(random_day_number());
        wait_all_dates_out();

        sender_idle_pct = 0;
        repeat (PHASE_ITEMS) day_numbers_pending.push_back(random_day_number());
        wait_all_dates_out();

        // let any stray result show up
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
